// ===== design/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types, lamp codes and small arithmetic helpers for the two-way
// traffic light controller.
// ----------------------------------------------------------------------------
package tlc_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL      = 2'd0,
        MODE_EDIT_RED    = 2'd1,
        MODE_EDIT_YELLOW = 2'd2,
        MODE_EDIT_GREEN  = 2'd3
    } mode_t;

    // Lamp bits: red1 yellow1 green1 red2 yellow2 green2 from bit 0 up
    localparam logic [5:0] LAMP_OFF = 6'h00;
    localparam logic [5:0] LAMP_R1  = 6'h01;
    localparam logic [5:0] LAMP_Y1  = 6'h02;
    localparam logic [5:0] LAMP_G1  = 6'h04;
    localparam logic [5:0] LAMP_R2  = 6'h08;
    localparam logic [5:0] LAMP_Y2  = 6'h10;
    localparam logic [5:0] LAMP_G2  = 6'h20;

    localparam logic [6:0] MAX_PHASE_TIME = 7'd99;
    localparam logic [6:0] RED_RESET      = 7'd5;
    localparam logic [6:0] YELLOW_RESET   = 7'd2;
    localparam logic [6:0] GREEN_RESET    = 7'd2;

    typedef struct packed {
        logic second_tick;
        logic blink_tick;
        logic mode_press;
        logic increment_press;
        logic commit_press;
    } event_t;

    typedef struct packed {
        logic [5:0] lamps;
        mode_t      mode;
        logic [6:0] left_value;
        logic [6:0] right_value;
    } result_t;

    // Values below 300 reduced modulo 100
    function automatic logic [6:0] mod100(input logic [8:0] v);
        logic [8:0] d;
        if (v >= 9'd200)
            d = v - 9'd200;
        else if (v >= 9'd100)
            d = v - 9'd100;
        else
            d = v;
        return d[6:0];
    endfunction

    // Tens digit of a value below 100 by reciprocal multiply
    function automatic logic [3:0] tens_digit(input logic [6:0] v);
        logic [14:0] p;
        p = {8'd0, v} * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] ones_digit(input logic [6:0] v);
        logic [6:0] t10;
        logic [6:0] r;
        t10 = {3'd0, tens_digit(v)} * 7'd10;
        r   = v - t10;
        return r[3:0];
    endfunction

endpackage

// ===== design/two_way_traffic_light_controller_top.sv =====
// ----------------------------------------------------------------------------
// two_way_traffic_light_controller_top
// Two-road traffic light controller with a normal countdown mode and three
// edit modes for the red, yellow and green phase times.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | word contents
//  --------+----------------------------+------------------------------------
//  event   | item_valid / item_stall    | second_tick blink_tick mode_press
//          |                            | increment_press commit_press
//  result  | result_valid / result_stall| lamps mode left_ones left_tens
//          |                            | right_ones right_tens
//
//  One event word in, one result word out, through the input register
//  and then the result register; a new word is taken every cycle while
//  item_stall is low. The step logic sits between the two registers.
//  Reset (rst_n low) puts the controller in normal mode with counter 0,
//  red 5, yellow 2, green 2, all lamps off and both displays at 00.
//  A stalled result holds in the result register; the input register keeps
//  taking words until it is full behind a stalled result, then item_stall
//  rises.
// ----------------------------------------------------------------------------
module two_way_traffic_light_controller_top (
    input  logic       clk,
    input  logic       rst_n,
    // event channel
    input  logic       item_valid,
    output logic       item_stall,
    input  logic       second_tick,
    input  logic       blink_tick,
    input  logic       mode_press,
    input  logic       increment_press,
    input  logic       commit_press,
    // result channel
    output logic       result_valid,
    input  logic       result_stall,
    output logic [5:0] lamps,
    output logic [1:0] mode,
    output logic [3:0] left_ones,
    output logic [3:0] left_tens,
    output logic [3:0] right_ones,
    output logic [3:0] right_tens
);
    import tlc_pkg::*;

    event_t  ev_in;
    event_t  ev_held;
    logic    held_valid;
    logic    res_open;
    logic    fire;
    logic    take;
    result_t step_result;

    assign ev_in.second_tick     = second_tick;
    assign ev_in.blink_tick      = blink_tick;
    assign ev_in.mode_press      = mode_press;
    assign ev_in.increment_press = increment_press;
    assign ev_in.commit_press    = commit_press;

    // Result register is free when empty or being drained this cycle
    assign take       = result_valid && !result_stall;
    assign res_open   = !result_valid || !result_stall;
    // Advance the held word into the step logic when the result side is open
    assign fire       = held_valid && res_open;
    // Hold the input side only when a word waits behind a stalled result
    assign item_stall = held_valid && !res_open;

    tlc_input_reg u_input_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (!item_stall),
        .word_valid (item_valid),
        .word_in    (ev_in),
        .held_valid (held_valid),
        .held_word  (ev_held)
    );

    tlc_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .ev          (ev_held),
        .step_result (step_result)
    );

    tlc_result_reg u_result_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .take        (take),
        .step_result (step_result),
        .word_valid  (result_valid),
        .lamps       (lamps),
        .mode        (mode),
        .left_ones   (left_ones),
        .left_tens   (left_tens),
        .right_ones  (right_ones),
        .right_tens  (right_tens)
    );

endmodule

// ===== design/tlc_input_reg.sv =====
// ----------------------------------------------------------------------------
// tlc_input_reg
// Input register: captures one event word whenever the input side is open.
// ----------------------------------------------------------------------------
module tlc_input_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  logic            word_valid,
    input  tlc_pkg::event_t word_in,
    output logic            held_valid,
    output tlc_pkg::event_t held_word
);
    import tlc_pkg::*;

    logic   valid_reg;
    event_t word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= word_valid;
        end
    end

    // Payload needs no reset; take it only when a word enters
    always_ff @(posedge clk)
    begin
        if (load && word_valid)
        begin
            word_reg <= word_in;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

// ===== design/tlc_engine.sv =====
// ----------------------------------------------------------------------------
// tlc_engine
// Controller state and the single-pass step: normal countdown, road 2 split
// and the three edit modes. State advances when fire is high.
// ----------------------------------------------------------------------------
module tlc_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  tlc_pkg::event_t  ev,
    output tlc_pkg::result_t step_result
);
    import tlc_pkg::*;

    mode_t      mode_reg,    mode_next;
    logic [8:0] counter_reg, counter_next;
    logic [6:0] red_reg,     red_next;
    logic [6:0] yellow_reg,  yellow_next;
    logic [6:0] green_reg,   green_next;
    logic [6:0] cand_reg,    cand_next;
    logic [6:0] g2_reg,      g2_next;
    logic [6:0] y2_reg,      y2_next;
    logic [5:0] lamp_reg,    lamp_next;
    logic [6:0] left_reg,    left_next;
    logic [6:0] right_reg,   right_next;

    logic [7:0] gy;
    logic [8:0] reload;
    mode_t      mode_after;
    logic [5:0] blink_mask;

    assign gy     = {1'b0, green_reg} + {1'b0, yellow_reg};
    assign reload = {1'b0, gy} + {2'b00, red_reg};

    always_comb
    begin
        mode_next    = mode_reg;
        counter_next = counter_reg;
        red_next     = red_reg;
        yellow_next  = yellow_reg;
        green_next   = green_reg;
        cand_next    = cand_reg;
        g2_next      = g2_reg;
        y2_next      = y2_reg;
        lamp_next    = lamp_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        mode_after   = mode_reg;
        blink_mask   = LAMP_G1 | LAMP_G2;

        if (mode_reg == MODE_NORMAL)
        begin
            if (ev.mode_press)
            begin
                lamp_next = LAMP_OFF;
                cand_next = red_reg;
                mode_next = MODE_EDIT_RED;
            end
            if (ev.second_tick)
            begin
                // Road 1 red: road 2 runs its green then yellow slot
                priority if (counter_reg > {1'b0, gy})
                begin
                    left_next = mod100(counter_reg - {1'b0, gy});
                    priority if (g2_reg != 7'd0)
                    begin
                        lamp_next  = LAMP_R1 | LAMP_G2;
                        right_next = mod100({2'b00, g2_reg});
                        g2_next    = g2_reg - 7'd1;
                    end
                    else if (y2_reg != 7'd0)
                    begin
                        lamp_next  = LAMP_R1 | LAMP_Y2;
                        right_next = mod100({2'b00, y2_reg});
                        y2_next    = y2_reg - 7'd1;
                    end
                    else
                    begin
                        lamp_next = LAMP_R1 | LAMP_G2;
                    end
                end
                else if (counter_reg > {2'b00, yellow_reg})
                begin
                    left_next  = mod100(counter_reg - {2'b00, yellow_reg});
                    right_next = mod100(counter_reg);
                    lamp_next  = LAMP_G1 | LAMP_R2;
                end
                else if (counter_reg != 9'd0)
                begin
                    left_next  = mod100(counter_reg);
                    right_next = mod100(counter_reg);
                    lamp_next  = LAMP_Y1 | LAMP_R2;
                end
                else
                begin
                    lamp_next = lamp_next;
                end

                if (counter_reg == 9'd0)
                begin
                    counter_next = reload;
                    priority if (red_reg > green_reg)
                    begin
                        g2_next = green_reg;
                        y2_next = red_reg - green_reg;
                    end
                    else if (red_reg > yellow_reg)
                    begin
                        y2_next = yellow_reg;
                        g2_next = red_reg - yellow_reg;
                    end
                    else
                    begin
                        g2_next = red_reg;
                        y2_next = 7'd0;
                    end
                end
                else
                begin
                    counter_next = counter_reg - 9'd1;
                end
            end
        end
        else
        begin
            if (ev.mode_press)
            begin
                lamp_next  = LAMP_OFF;
                mode_after = mode_t'(mode_reg + 2'd1);
            end
            unique case (mode_reg)
                MODE_EDIT_RED:    blink_mask = LAMP_R1 | LAMP_R2;
                MODE_EDIT_YELLOW: blink_mask = LAMP_Y1 | LAMP_Y2;
                default:          blink_mask = LAMP_G1 | LAMP_G2;
            endcase
            if (ev.blink_tick)
            begin
                lamp_next = lamp_next ^ blink_mask;
            end
            left_next  = {5'd0, mode_reg};
            right_next = mod100({2'b00, cand_reg});
            if (ev.increment_press)
            begin
                cand_next = (cand_reg >= MAX_PHASE_TIME) ? MAX_PHASE_TIME
                                                         : cand_reg + 7'd1;
            end
            if (ev.commit_press)
            begin
                unique case (mode_reg)
                    MODE_EDIT_RED:    red_next    = cand_next;
                    MODE_EDIT_YELLOW: yellow_next = cand_next;
                    default:          green_next  = cand_next;
                endcase
            end
            if (ev.mode_press)
            begin
                mode_next = mode_after;
                unique case (mode_after)
                    MODE_EDIT_RED:    cand_next = red_next;
                    MODE_EDIT_YELLOW: cand_next = yellow_next;
                    MODE_EDIT_GREEN:  cand_next = green_next;
                    default:          cand_next = cand_next;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            counter_reg <= 9'd0;
            red_reg     <= RED_RESET;
            yellow_reg  <= YELLOW_RESET;
            green_reg   <= GREEN_RESET;
            cand_reg    <= 7'd0;
            g2_reg      <= 7'd0;
            y2_reg      <= 7'd0;
            lamp_reg    <= LAMP_OFF;
            left_reg    <= 7'd0;
            right_reg   <= 7'd0;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            counter_reg <= counter_next;
            red_reg     <= red_next;
            yellow_reg  <= yellow_next;
            green_reg   <= green_next;
            cand_reg    <= cand_next;
            g2_reg      <= g2_next;
            y2_reg      <= y2_next;
            lamp_reg    <= lamp_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
        end
    end

    assign step_result.lamps       = lamp_next;
    assign step_result.mode        = mode_next;
    assign step_result.left_value  = left_next;
    assign step_result.right_value = right_next;

endmodule

// ===== design/tlc_result_reg.sv =====
// ----------------------------------------------------------------------------
// tlc_result_reg
// Result register: splits shown values into digits and holds the result
// word until the output side takes it.
// ----------------------------------------------------------------------------
module tlc_result_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic             take,
    input  tlc_pkg::result_t step_result,
    output logic             word_valid,
    output logic [5:0]       lamps,
    output logic [1:0]       mode,
    output logic [3:0]       left_ones,
    output logic [3:0]       left_tens,
    output logic [3:0]       right_ones,
    output logic [3:0]       right_tens
);
    import tlc_pkg::*;

    logic       valid_reg;
    logic [5:0] lamps_reg;
    logic [1:0] mode_reg;
    logic [3:0] lo_reg, lt_reg, ro_reg, rt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            lamps_reg <= step_result.lamps;
            mode_reg  <= step_result.mode;
            lo_reg    <= ones_digit(step_result.left_value);
            lt_reg    <= tens_digit(step_result.left_value);
            ro_reg    <= ones_digit(step_result.right_value);
            rt_reg    <= tens_digit(step_result.right_value);
        end
    end

    assign word_valid = valid_reg;
    assign lamps      = lamps_reg;
    assign mode       = mode_reg;
    assign left_ones  = lo_reg;
    assign left_tens  = lt_reg;
    assign right_ones = ro_reg;
    assign right_tens = rt_reg;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-way traffic light controller. Event words
// are driven through the valid/stall input channel, and each one is also
// stepped through a behavioral copy of the controller kept in this module.
// Every result word must match, field by field, the oldest predicted panel
// (lamps, mode and the four display digits).
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tlc_pkg::*;

    // Watchdog in clock cycles. The slowest legal run is far below this.
    localparam int CYCLE_LIMIT = 250000;
    // Cycles to keep watching after the last predicted word has come out
    localparam int DRAIN_PAD   = 10;
    // Words per idle/stall mix in the random part
    localparam int MIX_WORDS   = 160;

    // One predicted result word, in the form the ports present it
    typedef struct {
        logic [5:0] lamps;
        mode_t      mode;
        logic [3:0] left_ones;
        logic [3:0] left_tens;
        logic [3:0] right_ones;
        logic [3:0] right_tens;
    } panel_t;

    // ------------------------------------------------------------------------
    // Block ports. Every input starts at a known value at time zero.
    // ------------------------------------------------------------------------
    logic       clk             = 1'b0;
    logic       rst_n           = 1'b0;
    logic       item_valid      = 1'b0;
    logic       item_stall;
    logic       second_tick     = 1'b0;
    logic       blink_tick      = 1'b0;
    logic       mode_press      = 1'b0;
    logic       increment_press = 1'b0;
    logic       commit_press    = 1'b0;
    logic       result_valid;
    logic       result_stall    = 1'b0;
    logic [5:0] lamps;
    logic [1:0] mode;
    logic [3:0] left_ones;
    logic [3:0] left_tens;
    logic [3:0] right_ones;
    logic [3:0] right_tens;

    two_way_traffic_light_controller_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .second_tick     (second_tick),
        .blink_tick      (blink_tick),
        .mode_press      (mode_press),
        .increment_press (increment_press),
        .commit_press    (commit_press),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .lamps           (lamps),
        .mode            (mode),
        .left_ones       (left_ones),
        .left_tens       (left_tens),
        .right_ones      (right_ones),
        .right_tens      (right_tens)
    );

    // 8 ns clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    panel_t      panel_q[$];          // predicted words, oldest first
    int          fail_count     = 0;
    int          words_sent     = 0;
    int          words_checked  = 0;
    int          edit_entries   = 0;
    int          src_idle_pct   = 0;  // only the stimulus process touches this
    int          sink_stall_pct = 0;  // written with NBAs, read by the stall process
    int unsigned cycle_count    = 0;

    // Long hold-off request: flip hold_toggle to start a stall; hold_len sets its length
    logic        hold_toggle    = 1'b0;
    logic        hold_seen      = 1'b0;
    int          hold_len       = 0;
    int          hold_left      = 0;

    // ------------------------------------------------------------------------
    // Controller state as the bench tracks it
    // ------------------------------------------------------------------------
    mode_t      cur_mode;
    logic [8:0] cycle_cnt;
    logic [6:0] red_t;
    logic [6:0] yellow_t;
    logic [6:0] green_t;
    logic [6:0] cand_t;
    logic [6:0] g2_left;
    logic [6:0] y2_left;
    logic [5:0] lamp_q;
    logic [6:0] shown_l;
    logic [6:0] shown_r;

    task automatic reset_lights();
        cur_mode  = MODE_NORMAL;
        cycle_cnt = '0;
        red_t     = RED_RESET;
        yellow_t  = YELLOW_RESET;
        green_t   = GREEN_RESET;
        cand_t    = '0;
        g2_left   = '0;
        y2_left   = '0;
        lamp_q    = LAMP_OFF;
        shown_l   = '0;
        shown_r   = '0;
    endtask

    // Displays only hold two digits; larger values drop the hundreds
    function automatic logic [6:0] wrap100(input logic [8:0] v);
        return 7'(v % 9'd100);
    endfunction

    // One second in normal mode: pick the lamp phase from the countdown,
    // spend road 2 slots during road 1 red, and reload the cycle at zero.
    task automatic count_second();
        logic [8:0] gy;
        gy = 9'(green_t) + 9'(yellow_t);
        if (cycle_cnt > gy)
        begin
            shown_l = wrap100(cycle_cnt - gy);
            if (g2_left != 0)
            begin
                lamp_q  = LAMP_R1 | LAMP_G2;
                shown_r = wrap100(9'(g2_left));
                g2_left = g2_left - 7'd1;
            end
            else if (y2_left != 0)
            begin
                lamp_q  = LAMP_R1 | LAMP_Y2;
                shown_r = wrap100(9'(y2_left));
                y2_left = y2_left - 7'd1;
            end
            else
            begin
                // both road 2 slots spent: hold green2, leave right display
                lamp_q = LAMP_R1 | LAMP_G2;
            end
        end
        else if (cycle_cnt > 9'(yellow_t))
        begin
            shown_l = wrap100(cycle_cnt - 9'(yellow_t));
            shown_r = wrap100(cycle_cnt);
            lamp_q  = LAMP_G1 | LAMP_R2;
        end
        else if (cycle_cnt != 0)
        begin
            shown_l = wrap100(cycle_cnt);
            shown_r = wrap100(cycle_cnt);
            lamp_q  = LAMP_Y1 | LAMP_R2;
        end

        if (cycle_cnt == 0)
        begin
            // reload; lamps and displays keep what they show
            cycle_cnt = gy + 9'(red_t);
            if (red_t > green_t)
            begin
                g2_left = green_t;
                y2_left = red_t - green_t;
            end
            else if (red_t > yellow_t)
            begin
                y2_left = yellow_t;
                g2_left = red_t - yellow_t;
            end
            else
            begin
                g2_left = red_t;
                y2_left = '0;
            end
        end
        else
        begin
            cycle_cnt = cycle_cnt - 9'd1;
        end
    endtask

    // Advance the tracked controller by one event word and form its panel
    task automatic advance_lights(input event_t ev, output panel_t p);
        mode_t      nxt;
        logic [5:0] pair;
        if (cur_mode == MODE_NORMAL)
        begin
            if (ev.mode_press)
            begin
                lamp_q   = LAMP_OFF;
                cand_t   = red_t;
                cur_mode = MODE_EDIT_RED;
                edit_entries++;
            end
            if (ev.second_tick)
                count_second();
        end
        else
        begin
            nxt = cur_mode;
            if (ev.mode_press)
            begin
                lamp_q = LAMP_OFF;
                nxt    = (cur_mode == MODE_EDIT_GREEN) ? MODE_NORMAL
                                                       : mode_t'(cur_mode + 2'd1);
            end
            if (ev.blink_tick)
            begin
                case (cur_mode)
                    MODE_EDIT_RED:    pair = LAMP_R1 | LAMP_R2;
                    MODE_EDIT_YELLOW: pair = LAMP_Y1 | LAMP_Y2;
                    default:          pair = LAMP_G1 | LAMP_G2;
                endcase
                lamp_q = lamp_q ^ pair;
            end
            // displays show the candidate before this word's increment
            shown_l = {5'd0, cur_mode};
            shown_r = wrap100(9'(cand_t));
            if (ev.increment_press)
                cand_t = (cand_t >= MAX_PHASE_TIME) ? MAX_PHASE_TIME : cand_t + 7'd1;
            if (ev.commit_press)
            begin
                case (cur_mode)
                    MODE_EDIT_RED:    red_t    = cand_t;
                    MODE_EDIT_YELLOW: yellow_t = cand_t;
                    default:          green_t  = cand_t;
                endcase
            end
            if (ev.mode_press)
            begin
                cur_mode = nxt;
                case (nxt)
                    MODE_EDIT_RED:    cand_t = red_t;
                    MODE_EDIT_YELLOW: cand_t = yellow_t;
                    MODE_EDIT_GREEN:  cand_t = green_t;
                    default:          ;
                endcase
            end
        end

        p.lamps      = lamp_q;
        p.mode       = cur_mode;
        p.left_ones  = 4'(shown_l % 7'd10);
        p.left_tens  = 4'(shown_l / 7'd10);
        p.right_ones = 4'(shown_r % 7'd10);
        p.right_tens = 4'(shown_r / 7'd10);
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall pattern and checking
    // ------------------------------------------------------------------------

    // Random stall at sink_stall_pct, overridden by a counted long hold-off
    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen    <= hold_toggle;
            hold_left    <= hold_len;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare every accepted result word against the oldest prediction
    always @(posedge clk)
    begin : check_results
        panel_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (panel_q.size() == 0)
            begin
                $error("result word with nothing predicted: lamps=%0d mode=%0d", lamps, mode);
                fail_count++;
            end
            else
            begin
                want = panel_q.pop_front();
                check_field("lamps",      want.lamps,      lamps);
                check_field("mode",       int'(want.mode), mode);
                check_field("left_ones",  want.left_ones,  left_ones);
                check_field("left_tens",  want.left_tens,  left_tens);
                check_field("right_ones", want.right_ones, right_ones);
                check_field("right_tens", want.right_tens, right_tens);
                words_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Event side
    // ------------------------------------------------------------------------

    function automatic event_t mk_event(input logic sec, input logic blink,
                                        input logic mpress, input logic inc,
                                        input logic commit);
        event_t ev;
        ev.second_tick     = sec;
        ev.blink_tick      = blink;
        ev.mode_press      = mpress;
        ev.increment_press = inc;
        ev.commit_press    = commit;
        return ev;
    endfunction

    // Send one event word. Valid stays high across back-to-back words; it
    // only drops for an idle gap. The word is accepted at the first edge
    // where stall is low, and the prediction is taken right there.
    task automatic offer_event(input event_t ev);
        panel_t p;
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid      <= 1'b1;
        second_tick     <= ev.second_tick;
        blink_tick      <= ev.blink_tick;
        mode_press      <= ev.mode_press;
        increment_press <= ev.increment_press;
        commit_press    <= ev.commit_press;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        advance_lights(ev, p);
        panel_q.push_back(p);
        words_sent++;
    endtask

    // Drop valid and hold off until every predicted word has come out
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (panel_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct <= sink_pct;
    endtask

    // Legal-looking traffic that mostly counts, with short edit sessions.
    // Bits are weighted by the current mode so edits stay short and the
    // phase times grow slowly in this part of the run.
    function automatic event_t random_event();
        event_t ev;
        if (cur_mode == MODE_NORMAL)
        begin
            ev.second_tick     = ($urandom_range(99) < 70);
            ev.blink_tick      = ($urandom_range(99) < 20);
            ev.mode_press      = ($urandom_range(99) < 3);
            ev.increment_press = ($urandom_range(99) < 10);
            ev.commit_press    = ($urandom_range(99) < 10);
        end
        else
        begin
            ev.second_tick     = ($urandom_range(99) < 20);
            ev.blink_tick      = ($urandom_range(99) < 50);
            ev.mode_press      = ($urandom_range(99) < 15);
            ev.increment_press = ($urandom_range(99) < 25);
            ev.commit_press    = ($urandom_range(99) < 20);
        end
        return ev;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked words walking every mode and the odd corners
    task automatic test_directed_cases();
        set_idling(0, 0);
        // first second with counter at zero: reload only, panel stays dark
        offer_event(mk_event(1, 0, 0, 0, 0));
        // blink, increment and commit have no effect in normal mode
        offer_event(mk_event(0, 1, 0, 1, 1));
        // road 1 red: road 2 green slot, then its yellow slot
        repeat (3) offer_event(mk_event(1, 0, 0, 0, 0));
        // mode press together with a second: lamps off, then the tick still runs
        offer_event(mk_event(1, 0, 1, 0, 0));
        // edit red: second ignored, blink on, increment, blink off with commit
        offer_event(mk_event(1, 0, 0, 0, 0));
        offer_event(mk_event(0, 1, 0, 0, 0));
        offer_event(mk_event(0, 0, 0, 1, 0));
        offer_event(mk_event(0, 1, 0, 1, 1));
        // everything at once: press, blink of the old pair, increment, commit
        offer_event(mk_event(0, 1, 1, 1, 1));
        // edit yellow
        offer_event(mk_event(0, 1, 0, 0, 0));
        offer_event(mk_event(0, 0, 0, 1, 1));
        offer_event(mk_event(0, 0, 1, 0, 0));
        // edit green
        offer_event(mk_event(0, 1, 0, 1, 0));
        offer_event(mk_event(0, 0, 0, 0, 1));
        // leave edit with a blink in the same word: green pair lit in normal mode
        offer_event(mk_event(0, 1, 1, 0, 0));
        // blink ignored again, then run through the phases with new times
        offer_event(mk_event(0, 1, 0, 0, 0));
        repeat (7) offer_event(mk_event(1, 0, 0, 0, 0));
    endtask

    // Random traffic under each idle/stall mix in turn
    task automatic test_random_traffic();
        set_idling(0, 0);
        repeat (MIX_WORDS) offer_event(random_event());
        set_idling(78, 0);
        repeat (MIX_WORDS) offer_event(random_event());
        set_idling(0, 78);
        repeat (MIX_WORDS) offer_event(random_event());
        set_idling(15, 15);
        repeat (MIX_WORDS) offer_event(random_event());
    endtask

    // Hold the result side for a long stretch while words keep coming, so
    // the block fills and pushes back; then pause until it has drained.
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_len    <= 300;
        hold_toggle <= ~hold_toggle;
        repeat (40) offer_event(random_event());
        wait_drained();
    endtask

    // Drive every phase time up to the ceiling, then count long enough for
    // a full cycle so countdowns above 99 show on the displays.
    // Phase times never shrink, so this runs last.
    task automatic test_long_phase_times();
        set_idling(15, 15);
        while (cur_mode != MODE_EDIT_RED)
            offer_event(mk_event($urandom_range(1), $urandom_range(1), 1, 0, 0));
        repeat (3)
        begin
            // push past the ceiling; commits land at random along the way
            repeat (106)
                offer_event(mk_event($urandom_range(1), $urandom_range(1), 0, 1,
                                     $urandom_range(9) == 0));
            offer_event(mk_event(0, $urandom_range(1), 0, 0, 1));
            offer_event(mk_event(0, $urandom_range(1), 1, 0, 0));
        end
        // normal mode again; blink, increment and commit bits are noise here
        repeat (400)
            offer_event(mk_event(1, $urandom_range(1), 0, $urandom_range(1),
                                 $urandom_range(1)));
    endtask

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------
    initial
    begin
        reset_lights();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_traffic();
        test_backpressure();
        test_long_phase_times();

        // wait out the last words, then keep watching for strays
        wait_drained();
        repeat (DRAIN_PAD) @(posedge clk);
        if (panel_q.size() != 0)
        begin
            $error("%0d predicted words never came out", panel_q.size());
            fail_count++;
        end

        $display("Covered %0d event words, %0d result words compared, %0d edit sessions.",
                 words_sent, words_checked, edit_entries);
        $display("Idle/stall mixes, one long hold-off; phase times now %0d/%0d/%0d.",
                 red_t, yellow_t, green_t);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tlc_pkg.sv
design/tlc_input_reg.sv
design/tlc_engine.sv
design/tlc_result_reg.sv
design/two_way_traffic_light_controller_top.sv
tb/tb_top.sv
